[hdl/time_slot_table_scheduler_top_macros.svh]
// Assertion macros shared by the scheduler RTL.
`ifndef TIME_SLOT_TABLE_SCHEDULER_TOP_MACROS_SVH
`define TIME_SLOT_TABLE_SCHEDULER_TOP_MACROS_SVH
`ifndef ASSERT_OFF
// Checked at each rising edge, masked while reset is high.
`define TSTS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked at each rising edge outside reset, including the edge after reset.
`define TSTS_ASSERT_POST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) !rst |-> prop) else $error(msg);
`else
`define TSTS_ASSERT(lbl, clk, rst, prop, msg)
`define TSTS_ASSERT_POST(lbl, clk, rst, prop, msg)
`endif
`endif

[hdl/tsts_pkg.sv]
// Types, codes and constants of the slot table scheduler.
`timescale 1ns / 1ps
package tsts_pkg;

  localparam int SLOTS     = 64;
  localparam int SLOT_W    = 6;
  localparam int MAX_TASKS = 16;
  localparam int TASK_W    = 4;
  localparam int CNT_W     = 5;
  localparam int LEN_W     = 7;
  localparam int IO_W      = 20;
  localparam int SLICE_W   = 16;

  typedef enum logic [1:0] {
    OP_ADMIT, OP_TICK, OP_EXIT, OP_BLOCK
  } op_t;

  typedef enum logic [2:0] {
    ACT_ADMITTED, ACT_REJECTED, ACT_STARTED, ACT_PREEMPTED,
    ACT_UNBLOCKED, ACT_RELEASED, ACT_BLOCKED, ACT_IDLE
  } action_t;

  typedef enum logic [2:0] {
    STS_OK, STS_REF_MISSING, STS_OVERRUN, STS_CONFLICT, STS_ID_IN_USE, STS_NO_RUN
  } status_t;

  typedef enum logic [1:0] {
    REG_SLICE_TICKS, REG_PERIOD_SLOTS, REG_IO_BLOCK_TICKS
  } reg_idx_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_AD_REF, ST_AD_CHK, ST_AD_SCAN, ST_AD_FILL,
    ST_TK_RD, ST_TK_UPD, ST_TK_SLICE, ST_TK_OWN, ST_TK_START, ST_TK_END,
    ST_EX_RD, ST_EX_CLR, ST_BK_RD, ST_FIN
  } seq_state_t;

  typedef struct packed {
    action_t             act;
    status_t             sts;
    logic [TASK_W-1:0]   task_ref;
    logic [SLOT_W-1:0]   slot;
  } result_t;

  typedef struct packed {
    logic [SLOT_W-1:0] start;
    logic [LEN_W-1:0]  len;
    logic [IO_W-1:0]   io;
  } task_word_t;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] addr;
    logic [TASK_W-1:0] wdata;
  } slot_req_t;

  typedef struct packed {
    logic              we;
    logic [TASK_W-1:0] addr;
    task_word_t        wdata;
  } task_req_t;

  typedef struct packed {
    logic [SLICE_W-1:0] slice_lim;
    logic [LEN_W-1:0]   period;
    logic [IO_W-1:0]    io_ticks;
  } cfg_t;

endpackage

[hdl/time_slot_table_scheduler_top.sv]
// Top level of the slot table scheduler: configuration registers and memories.
`timescale 1ns / 1ps
// Usage:
//  req channel (req_valid/req_stall) carries one command transaction: admit,
//  tick, exit or block. rsp channel (rsp_valid/rsp_stall) returns one or more
//  result transactions per command; last marks the final one.
//  cfg channel (cfg_valid/cfg_ready, ready always high) writes slice_ticks,
//  period_slots and io_block_ticks; write only while no command is in flight.
// Sequencing: one command at a time; req_stall is high from
//  acceptance until the final result is loaded into the output register.
//  Admit scans the slot valid bits, then does one slot memory write per
//  claimed slot. Tick with no active task returns one idle result; else it
//  walks all 16 task entries, with a read-modify-write of the I/O counter
//  of each blocked task in the task memory, then does one slot memory read.
//  Exit clears the slot valid bit of each slot of the running task.
// Reset (rst, synchronous): all slots free, no task, no running task, slot
//  and slice counters zero, registers at their defaults. No clearing pass.
// A stalled receiver holds the output register; the sequencer keeps one more
//  result pending and waits until the output register frees up.
module time_slot_table_scheduler_top import tsts_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  logic [1:0]            op,
  input  logic [TASK_W-1:0]     task_id,
  input  logic                  start_is_relative,
  input  logic [SLOT_W-1:0]     start_slot,
  input  logic [TASK_W-1:0]     ref_task_id,
  input  logic [LEN_W-1:0]      burst_slots,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output logic [2:0]            action,
  output logic [2:0]            status,
  output logic [TASK_W-1:0]     task_ref,
  output logic [SLOT_W-1:0]     slot_now,
  output logic                  last,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [IO_W-1:0]       cfg_data
);
  logic [SLICE_W-1:0] slice_ticks;
  logic [LEN_W-1:0]   period_slots;
  logic [IO_W-1:0]    io_block_ticks;
  cfg_t               cfg;
  result_t            rsp;
  slot_req_t          slot_req;
  task_req_t          task_req;
  logic [TASK_W-1:0]  slot_rdata;
  task_word_t         task_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      slice_ticks    <= SLICE_W'(1000);
      period_slots   <= LEN_W'(60);
      io_block_ticks <= IO_W'(3000);
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_SLICE_TICKS:    slice_ticks    <= cfg_data[SLICE_W-1:0];
        REG_PERIOD_SLOTS:   period_slots   <= cfg_data[LEN_W-1:0];
        REG_IO_BLOCK_TICKS: io_block_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective values: zero slice and zero period act as one, period clamped to the table
  always_comb begin
    cfg.slice_lim = (slice_ticks == '0) ? SLICE_W'(1) : slice_ticks;
    if (period_slots == '0) begin
      cfg.period = LEN_W'(1);
    end else if (period_slots > LEN_W'(SLOTS)) begin
      cfg.period = LEN_W'(SLOTS);
    end else begin
      cfg.period = period_slots;
    end
    cfg.io_ticks = io_block_ticks;
  end

  tsts_slot_mem u_slot_mem (
    .clk   (clk),
    .req   (slot_req),
    .rdata (slot_rdata)
  );

  tsts_task_mem u_task_mem (
    .clk   (clk),
    .req   (task_req),
    .rdata (task_rdata)
  );

  tsts_seq u_seq (
    .clk               (clk),
    .rst               (rst),
    .cfg               (cfg),
    .req_valid         (req_valid),
    .req_stall         (req_stall),
    .op                (op),
    .task_id           (task_id),
    .start_is_relative (start_is_relative),
    .start_slot        (start_slot),
    .ref_task_id       (ref_task_id),
    .burst_slots       (burst_slots),
    .rsp_valid         (rsp_valid),
    .rsp_stall         (rsp_stall),
    .rsp               (rsp),
    .rsp_last          (last),
    .slot_req          (slot_req),
    .slot_rdata        (slot_rdata),
    .task_req          (task_req),
    .task_rdata        (task_rdata)
  );

  assign action   = rsp.act;
  assign status   = rsp.sts;
  assign task_ref = rsp.task_ref;
  assign slot_now = rsp.slot;
endmodule

[hdl/tsts_slot_mem.sv]
// Slot owner memory: one task id per slot, registered read.
`timescale 1ns / 1ps
module tsts_slot_mem import tsts_pkg::*; (
  input  logic              clk,
  input  slot_req_t         req,
  output logic [TASK_W-1:0] rdata
);
  logic [TASK_W-1:0] mem [SLOTS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    rdata <= mem[req.addr];
  end
endmodule

[hdl/tsts_task_mem.sv]
// Task descriptor memory: start, length and I/O countdown per task.
`timescale 1ns / 1ps
module tsts_task_mem import tsts_pkg::*; (
  input  logic       clk,
  input  task_req_t  req,
  output task_word_t rdata
);
  task_word_t mem [MAX_TASKS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    rdata <= mem[req.addr];
  end
endmodule

[hdl/tsts_seq.sv]
// Sequencer: admission, tick, exit and block handling plus the result stage.
`timescale 1ns / 1ps
`include "time_slot_table_scheduler_top_macros.svh"
module tsts_seq import tsts_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              req_valid,
  output logic              req_stall,
  input  logic [1:0]        op,
  input  logic [TASK_W-1:0] task_id,
  input  logic              start_is_relative,
  input  logic [SLOT_W-1:0] start_slot,
  input  logic [TASK_W-1:0] ref_task_id,
  input  logic [LEN_W-1:0]  burst_slots,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output result_t           rsp,
  output logic              rsp_last,
  output slot_req_t         slot_req,
  input  logic [TASK_W-1:0] slot_rdata,
  output task_req_t         task_req,
  input  task_word_t        task_rdata
);
  seq_state_t state, state_next;
  logic [TASK_W-1:0] id_q, id_q_next, ref_q, ref_q_next;
  logic rel_q, rel_q_next;
  logic [SLOT_W-1:0] sslot_q, sslot_q_next;
  logic [LEN_W-1:0] burst_q, burst_q_next, start_q, start_q_next, k, k_next;
  logic [CNT_W-1:0] tcnt, tcnt_next;
  logic [SLOTS-1:0] used, used_next;
  logic [MAX_TASKS-1:0] valid_v, valid_v_next, blocked_v, blocked_v_next;
  logic run_valid, run_valid_next;
  logic [TASK_W-1:0] running, running_next;
  logic [SLOT_W-1:0] cur, cur_next;
  logic [SLICE_W-1:0] slice, slice_next;
  logic [CNT_W-1:0] active, active_next;
  logic pend_valid, pend_valid_next;
  result_t pend, pend_next;
  logic rsp_valid_next, rsp_last_next;
  result_t rsp_next;

  logic can_push, emit_ok, do_emit, accept;
  result_t emit_res;
  logic [SLOT_W-1:0] sidx, cur_tick;
  logic [LEN_W-1:0] cur_inc;
  logic [LEN_W:0] run_end;
  logic [SLICE_W-1:0] slice_inc;
  logic [TASK_W-1:0] tidx;

  assign can_push  = !rsp_valid || !rsp_stall;
  assign emit_ok   = !pend_valid || can_push;
  assign accept    = req_valid && !req_stall;
  assign req_stall = (state != ST_IDLE);
  assign sidx      = SLOT_W'(start_q + k);
  assign tidx      = tcnt[TASK_W-1:0];
  assign run_end   = {1'b0, start_q} + {1'b0, burst_q};
  assign slice_inc = slice + SLICE_W'(1);
  assign cur_inc   = LEN_W'(cur) + LEN_W'(1);

  // slot index after this tick's slice update
  always_comb begin
    if (slice_inc >= cfg.slice_lim) begin
      cur_tick = (cur_inc >= cfg.period) ? '0 : cur_inc[SLOT_W-1:0];
    end else begin
      cur_tick = cur;
    end
  end

  always_comb begin
    state_next = state;
    id_q_next = id_q; ref_q_next = ref_q; rel_q_next = rel_q;
    sslot_q_next = sslot_q; burst_q_next = burst_q; start_q_next = start_q;
    k_next = k; tcnt_next = tcnt;
    used_next = used; valid_v_next = valid_v; blocked_v_next = blocked_v;
    run_valid_next = run_valid; running_next = running;
    cur_next = cur; slice_next = slice; active_next = active;
    pend_valid_next = pend_valid; pend_next = pend;
    rsp_valid_next = rsp_valid && rsp_stall;
    rsp_next = rsp; rsp_last_next = rsp_last;
    do_emit = 1'b0;
    emit_res = '{act: ACT_IDLE, sts: STS_OK, task_ref: '0, slot: '0};
    slot_req = '{we: 1'b0, addr: cur, wdata: id_q};
    task_req = '{we: 1'b0, addr: running, wdata: task_rdata};

    case (state)
      ST_IDLE: begin
        task_req.addr = (op_t'(op) == OP_ADMIT) ? ref_task_id : running;
        if (accept) begin
          case (op_t'(op))
            OP_ADMIT: begin
              id_q_next = task_id; ref_q_next = ref_task_id;
              rel_q_next = start_is_relative; sslot_q_next = start_slot;
              burst_q_next = burst_slots;
              state_next = ST_AD_REF;
            end
            OP_TICK: begin
              if (active == '0) begin
                do_emit = 1'b1;
                state_next = ST_FIN;
              end else begin
                tcnt_next = '0;
                state_next = ST_TK_RD;
              end
            end
            OP_EXIT, OP_BLOCK: begin
              if (!run_valid) begin
                do_emit = 1'b1;
                emit_res.sts = STS_NO_RUN;
                state_next = ST_FIN;
              end else begin
                state_next = (op_t'(op) == OP_EXIT) ? ST_EX_RD : ST_BK_RD;
              end
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end

      ST_AD_REF: begin
        task_req.addr = ref_q;
        emit_res.act = ACT_REJECTED;
        emit_res.task_ref = id_q;
        if (rel_q && (!valid_v[ref_q] || task_rdata.len == '0)) begin
          do_emit = 1'b1;
          emit_res.sts = STS_REF_MISSING;
          state_next = ST_FIN;
        end else begin
          start_q_next = rel_q ? (LEN_W'(task_rdata.start) + task_rdata.len)
                               : LEN_W'(sslot_q);
          state_next = ST_AD_CHK;
        end
      end

      ST_AD_CHK: begin
        emit_res.act = ACT_REJECTED;
        emit_res.task_ref = id_q;
        if (run_end > {1'b0, cfg.period}) begin
          do_emit = 1'b1;
          emit_res.sts = STS_OVERRUN;
          state_next = ST_FIN;
        end else begin
          k_next = '0;
          state_next = ST_AD_SCAN;
        end
      end

      ST_AD_SCAN: begin
        emit_res.act = ACT_REJECTED;
        emit_res.task_ref = id_q;
        if (k == burst_q) begin
          if (valid_v[id_q]) begin
            do_emit = 1'b1;
            emit_res.sts = STS_ID_IN_USE;
            state_next = ST_FIN;
          end else begin
            k_next = '0;
            state_next = ST_AD_FILL;
          end
        end else if (used[sidx]) begin
          do_emit = 1'b1;
          emit_res.sts = STS_CONFLICT;
          state_next = ST_FIN;
        end else begin
          k_next = k + LEN_W'(1);
        end
      end

      ST_AD_FILL: begin
        slot_req.addr = sidx;
        task_req.addr = id_q;
        if (k == burst_q) begin
          task_req.we = 1'b1;
          task_req.wdata = '{start: start_q[SLOT_W-1:0], len: burst_q, io: '0};
          valid_v_next[id_q] = 1'b1;
          blocked_v_next[id_q] = 1'b0;
          if (active == '0) begin
            cur_next = '0;
            slice_next = '0;
          end
          active_next = active + CNT_W'(1);
          do_emit = 1'b1;
          emit_res.act = ACT_ADMITTED;
          emit_res.task_ref = id_q;
          state_next = ST_FIN;
        end else begin
          slot_req.we = 1'b1;
          used_next[sidx] = 1'b1;
          k_next = k + LEN_W'(1);
        end
      end

      ST_TK_RD: begin
        task_req.addr = tidx;
        if (tcnt == CNT_W'(MAX_TASKS)) begin
          state_next = ST_TK_SLICE;
        end else if (blocked_v[tidx]) begin
          state_next = ST_TK_UPD;
        end else begin
          tcnt_next = tcnt + CNT_W'(1);
        end
      end

      ST_TK_UPD: begin
        task_req.addr = tidx;
        if (task_rdata.io <= IO_W'(1)) begin
          if (emit_ok) begin
            task_req.we = 1'b1;
            task_req.wdata.io = '0;
            blocked_v_next[tidx] = 1'b0;
            do_emit = 1'b1;
            emit_res.act = ACT_UNBLOCKED;
            emit_res.task_ref = tidx;
            tcnt_next = tcnt + CNT_W'(1);
            state_next = ST_TK_RD;
          end
        end else begin
          task_req.we = 1'b1;
          task_req.wdata.io = task_rdata.io - IO_W'(1);
          tcnt_next = tcnt + CNT_W'(1);
          state_next = ST_TK_RD;
        end
      end

      ST_TK_SLICE: begin
        slice_next = (slice_inc >= cfg.slice_lim) ? '0 : slice_inc;
        cur_next = cur_tick;
        slot_req.addr = cur_tick;
        state_next = ST_TK_OWN;
      end

      ST_TK_OWN: begin
        if (run_valid && !(used[cur] && slot_rdata == running)) begin
          if (emit_ok) begin
            do_emit = 1'b1;
            emit_res.act = ACT_PREEMPTED;
            emit_res.task_ref = running;
            run_valid_next = 1'b0;
            state_next = ST_TK_START;
          end
        end else begin
          state_next = ST_TK_START;
        end
      end

      ST_TK_START: begin
        if (!run_valid && used[cur] && valid_v[slot_rdata] && !blocked_v[slot_rdata]) begin
          if (emit_ok) begin
            do_emit = 1'b1;
            emit_res.act = ACT_STARTED;
            emit_res.task_ref = slot_rdata;
            run_valid_next = 1'b1;
            running_next = slot_rdata;
            state_next = ST_TK_END;
          end
        end else begin
          state_next = ST_TK_END;
        end
      end

      ST_TK_END: begin
        do_emit = !pend_valid;
        state_next = ST_FIN;
      end

      ST_EX_RD: begin
        start_q_next = LEN_W'(task_rdata.start);
        burst_q_next = task_rdata.len;
        k_next = '0;
        state_next = ST_EX_CLR;
      end

      ST_EX_CLR: begin
        if (k == burst_q) begin
          valid_v_next[running] = 1'b0;
          blocked_v_next[running] = 1'b0;
          if (active != '0) begin
            active_next = active - CNT_W'(1);
          end
          run_valid_next = 1'b0;
          do_emit = 1'b1;
          emit_res.act = ACT_RELEASED;
          emit_res.task_ref = running;
          state_next = ST_FIN;
        end else begin
          used_next[sidx] = 1'b0;
          k_next = k + LEN_W'(1);
        end
      end

      ST_BK_RD: begin
        task_req.we = 1'b1;
        task_req.wdata.io = cfg.io_ticks;
        blocked_v_next[running] = 1'b1;
        run_valid_next = 1'b0;
        do_emit = 1'b1;
        emit_res.act = ACT_BLOCKED;
        emit_res.task_ref = running;
        state_next = ST_FIN;
      end

      ST_FIN: begin
        if (can_push) begin
          rsp_next = pend;
          rsp_last_next = 1'b1;
          rsp_valid_next = 1'b1;
          pend_valid_next = 1'b0;
          state_next = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase

    // a new result pushes the held one out, not last
    if (do_emit) begin
      emit_res.slot = cur_next;
      if (pend_valid) begin
        rsp_next = pend;
        rsp_last_next = 1'b0;
        rsp_valid_next = 1'b1;
      end
      pend_next = emit_res;
      pend_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      used <= '0;
      valid_v <= '0;
      blocked_v <= '0;
      run_valid <= 1'b0;
      running <= '0;
      cur <= '0;
      slice <= '0;
      active <= '0;
      pend_valid <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      used <= used_next;
      valid_v <= valid_v_next;
      blocked_v <= blocked_v_next;
      run_valid <= run_valid_next;
      running <= running_next;
      cur <= cur_next;
      slice <= slice_next;
      active <= active_next;
      pend_valid <= pend_valid_next;
      rsp_valid <= rsp_valid_next;
    end
    id_q <= id_q_next;
    ref_q <= ref_q_next;
    rel_q <= rel_q_next;
    sslot_q <= sslot_q_next;
    burst_q <= burst_q_next;
    start_q <= start_q_next;
    k <= k_next;
    tcnt <= tcnt_next;
    pend <= pend_next;
    rsp <= rsp_next;
    rsp_last <= rsp_last_next;
  end

  `TSTS_ASSERT(a_run_valid_task, clk, rst, run_valid |-> valid_v[running], "running task not admitted")
  `TSTS_ASSERT(a_run_unblocked, clk, rst, run_valid |-> !blocked_v[running], "running task is blocked")
  `TSTS_ASSERT_POST(a_active_count, clk, rst, $countones(valid_v) == active, "active count mismatch")
  `TSTS_ASSERT(a_fin_has_result, clk, rst, state == ST_FIN |-> pend_valid, "final step without result")
endmodule
